// File: rtl/ccsa_pkg.sv
`default_nettype none

package ccsa_pkg;

   localparam int YearW   = 14;
   localparam int MonthW  = 4;
   localparam int DayW    = 5;
   localparam int HourW   = 5;
   localparam int MinuteW = 6;
   localparam int SecondW = 6;
   localparam int CountW  = 32;

   // day accumulator during the month walk: 31 + (2^32 + 59) / 86400 < 2^16
   localparam int DayAccW = 16;

   // dividend of the shared divider: a 32-bit count plus a field below 60
   localparam int DivW    = CountW + 1;
   localparam int DvsrW   = 6;

   localparam logic [1:0] OP_SET_DATE    = 2'd0;
   localparam logic [1:0] OP_SET_TIME    = 2'd1;
   localparam logic [1:0] OP_ADD_SECONDS = 2'd2;
   localparam logic [1:0] OP_READ        = 2'd3;

   localparam logic [YearW-1:0]   YearMax   = 14'd9999;
   localparam logic [MonthW-1:0]  MonthMax  = 4'd12;
   localparam logic [DayW-1:0]    DayMax    = 5'd31;
   localparam logic [HourW-1:0]   HourMax   = 5'd23;
   localparam logic [MinuteW-1:0] MinuteMax = 6'd59;
   localparam logic [SecondW-1:0] SecondMax = 6'd59;

   localparam logic [DvsrW-1:0] DvsrSixty = 6'd60;
   localparam logic [DvsrW-1:0] DvsrDay   = 6'd24;

   typedef struct packed {
      logic [1:0]        op;
      logic [YearW-1:0]  val_a;
      logic [5:0]        val_b;
      logic [CountW-1:0] val_c;
   } ccsa_req_type;

   typedef struct packed {
      logic [YearW-1:0]   out_year;
      logic [MonthW-1:0]  out_month;
      logic [DayW-1:0]    out_day;
      logic [HourW-1:0]   out_hour;
      logic [MinuteW-1:0] out_minute;
      logic [SecondW-1:0] out_second;
      logic               year_wrapped;
   } ccsa_rsp_type;

   typedef struct packed {
      logic set_date;
      logic clr_wrap;
      logic walk_load;
      logic walk_step;
   } ccsa_date_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_SEC,
      ST_DIV_MIN,
      ST_DIV_HOUR,
      ST_WALK,
      ST_DONE
   } ccsa_state_type;

   // y % 25 == 0 via reciprocal: floor(y * 5243 / 2^17) is exact for y < 43690
   function automatic logic is_leap(input logic [YearW-1:0] y);
      logic [26:0] prod;
      logic [9:0]  quot;
      logic [14:0] back;
      logic        div25;
      begin
         prod  = 27'(y) * 27'd5243;
         quot  = prod[26:17];
         back  = 15'(quot) * 15'd25;
         div25 = (back == {1'b0, y});
         is_leap = (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
      end
   endfunction

   function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                  input logic leap);
      logic [DayW-1:0] len;
      begin
         case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:                                      len = leap ? 5'd29 : 5'd28;
            default:                                   len = 5'd0;
         endcase
         month_days = len;
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/ccsa_div_unit.sv
`default_nettype none

// Division by 60 or 24 on one shared reciprocal multiplier with registered product and result.
// x / 60 = (x >> 2) / 15 and x / 24 = (x >> 3) / 3; the shifted-out bits rejoin the remainder.
module ccsa_div_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [ccsa_pkg::DivW-1:0]     dividend,
   input  wire logic [ccsa_pkg::DvsrW-1:0]    divisor,
   output logic                               done,
   output logic [ccsa_pkg::DivW-1:0]          quotient,
   output logic [ccsa_pkg::DvsrW-1:0]         remainder
);

   localparam int MulAW = 31;
   localparam int MulBW = 32;
   localparam int ProdW = MulAW + MulBW;

   // ceil(2^35 / 15) and ceil(2^33 / 3): exact for any 31-bit operand
   localparam logic [MulBW-1:0] RecipFifteen = 32'd2290649225;
   localparam logic [MulBW-1:0] RecipThree   = 32'd2863311531;

   logic [ccsa_pkg::DivW-1:0]  num_ff;
   logic                       by_day_ff;
   logic [ProdW-1:0]           prod_ff;
   logic [ccsa_pkg::DivW-1:0]  quo_ff, quo_in;
   logic [ccsa_pkg::DvsrW-1:0] rem_ff, rem_in;
   logic                       mul_pend_ff;
   logic                       prod_pend_ff;
   logic                       done_ff;

   logic [MulAW-1:0]           mul_a;
   logic [MulBW-1:0]           mul_b;
   logic [3:0]                 rem_fifteen;
   logic [1:0]                 rem_three;

   always_comb begin
      mul_a = by_day_ff ? {1'b0, num_ff[ccsa_pkg::DivW-1:3]} : num_ff[ccsa_pkg::DivW-1:2];
      mul_b = by_day_ff ? RecipThree : RecipFifteen;
   end

   // n - 15q == n + q mod 16 and n - 3q == n + q mod 4; both remainders fit those bits
   always_comb begin
      quo_in      = by_day_ff ? ccsa_pkg::DivW'(prod_ff[ProdW-1:33])
                              : ccsa_pkg::DivW'(prod_ff[ProdW-1:35]);
      rem_fifteen = num_ff[5:2] + quo_in[3:0];
      rem_three   = num_ff[4:3] + quo_in[1:0];
      rem_in      = by_day_ff ? {1'b0, rem_three, num_ff[2:0]} : {rem_fifteen, num_ff[1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_pend_ff  <= 1'b0;
         prod_pend_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         mul_pend_ff  <= start;
         prod_pend_ff <= mul_pend_ff;
         done_ff      <= prod_pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff    <= dividend;
         by_day_ff <= (divisor == ccsa_pkg::DvsrDay);
      end
      if (mul_pend_ff) begin
         prod_ff <= ProdW'(mul_a) * ProdW'(mul_b);
      end
      if (prod_pend_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// File: rtl/ccsa_date_unit.sv
`default_nettype none

// Date registers and the month-by-month walk that folds a day count into them.
module ccsa_date_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire ccsa_pkg::ccsa_date_ctrl_type     ctrl,
   input  wire logic [ccsa_pkg::YearW-1:0]       set_year,
   input  wire logic [ccsa_pkg::MonthW-1:0]      set_month,
   input  wire logic [ccsa_pkg::DayW-1:0]        set_day,
   input  wire logic [ccsa_pkg::DayAccW-1:0]     add_days,
   output logic [ccsa_pkg::YearW-1:0]            year,
   output logic [ccsa_pkg::MonthW-1:0]           month,
   output logic [ccsa_pkg::DayW-1:0]             day,
   output logic                                  wrapped,
   output logic                                  settled
);

   logic [ccsa_pkg::YearW-1:0]   year_ff, year_in;
   logic [ccsa_pkg::MonthW-1:0]  month_ff, month_in;
   logic [ccsa_pkg::DayAccW-1:0] day_ff, day_in;
   logic                         wrap_ff, wrap_in;
   logic                         leap_ff;

   logic [ccsa_pkg::DayW-1:0]    len;
   logic                         fits;

   // leap flag is registered from the year; February never follows a year step at once
   always_comb begin
      len  = ccsa_pkg::month_days(month_ff, leap_ff);
      fits = (day_ff <= ccsa_pkg::DayAccW'(len));
   end

   always_comb begin
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      wrap_in  = wrap_ff;
      if (ctrl.clr_wrap) begin
         wrap_in = 1'b0;
      end
      if (ctrl.set_date) begin
         year_in  = set_year;
         month_in = set_month;
         day_in   = ccsa_pkg::DayAccW'(set_day);
      end else if (ctrl.walk_load) begin
         day_in = day_ff + add_days;
      end else if (ctrl.walk_step && !fits) begin
         day_in = day_ff - ccsa_pkg::DayAccW'(len);
         if (month_ff >= ccsa_pkg::MonthMax) begin
            month_in = 4'd1;
            if (year_ff >= ccsa_pkg::YearMax) begin
               year_in = '0;
               wrap_in = 1'b1;
            end else begin
               year_in = year_ff + 14'd1;
            end
         end else begin
            month_in = month_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff  <= '0;
         month_ff <= '0;
         day_ff   <= '0;
         wrap_ff  <= 1'b0;
      end else begin
         year_ff  <= year_in;
         month_ff <= month_in;
         day_ff   <= day_in;
         wrap_ff  <= wrap_in;
      end
   end

   always_ff @(posedge clock) begin
      leap_ff <= ccsa_pkg::is_leap(year_ff);
   end

   assign year    = year_ff;
   assign month   = month_ff;
   assign day     = day_ff[ccsa_pkg::DayW-1:0];
   assign wrapped = wrap_ff;
   assign settled = fits;

endmodule

`default_nettype wire

// File: rtl/calendar_clock_seconds_adder.sv
`default_nettype none

// Channel        Direction  Handshake              Payload
// req_           in         req_valid/req_ready    ccsa_req_type (op, val_a, val_b, val_c)
// rsp_           out        rsp_valid/rsp_ready    ccsa_rsp_type (date, time, year_wrapped)
//
// Set date, set time and read: the sequencer goes to ST_DONE, which loads the result
// register once the output slot is free and then returns to idle for the next transaction.
// Add seconds: three divisions on the shared divider, by 60, 60 and 24, then a
// month-by-month walk of the date unit until the day fits; then ST_DONE loads the result.
// req_ready is high only while the sequencer is idle; one transaction at a time.
// A result waits in the output register while rsp_ready is low.
// Synchronous active-high reset clears date and time to zero.
module calendar_clock_seconds_adder (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire ccsa_pkg::ccsa_req_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output ccsa_pkg::ccsa_rsp_type      rsp_data
);

   ccsa_pkg::ccsa_state_type state_ff, state_in;

   logic [ccsa_pkg::HourW-1:0]   hour_ff, hour_in;
   logic [ccsa_pkg::MinuteW-1:0] minute_ff, minute_in;
   logic [ccsa_pkg::SecondW-1:0] second_ff, second_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   ccsa_pkg::ccsa_rsp_type       rsp_data_ff;

   logic                         accept;
   logic                         is_add;
   logic                         slot_free;
   logic                         load_rsp;

   logic                         div_start;
   logic [ccsa_pkg::DivW-1:0]    div_dividend;
   logic [ccsa_pkg::DvsrW-1:0]   div_divisor;
   logic                         div_done;
   logic [ccsa_pkg::DivW-1:0]    div_quo;
   logic [ccsa_pkg::DvsrW-1:0]   div_rem;

   ccsa_pkg::ccsa_date_ctrl_type date_ctrl;
   logic [ccsa_pkg::YearW-1:0]   set_year;
   logic [ccsa_pkg::MonthW-1:0]  set_month;
   logic [ccsa_pkg::DayW-1:0]    set_day;
   logic [ccsa_pkg::YearW-1:0]   cur_year;
   logic [ccsa_pkg::MonthW-1:0]  cur_month;
   logic [ccsa_pkg::DayW-1:0]    cur_day;
   logic                         wrapped;
   logic                         settled;

   assign req_ready = (state_ff == ccsa_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_add    = (req_data.op == ccsa_pkg::OP_ADD_SECONDS);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // saturate set values to the field limits
   always_comb begin
      set_year  = (req_data.val_a > ccsa_pkg::YearMax) ? ccsa_pkg::YearMax : req_data.val_a;
      set_month = (req_data.val_b > 6'(ccsa_pkg::MonthMax)) ? ccsa_pkg::MonthMax
                                                           : req_data.val_b[3:0];
      set_day   = (req_data.val_c > 32'(ccsa_pkg::DayMax)) ? ccsa_pkg::DayMax
                                                          : req_data.val_c[4:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ccsa_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = is_add ? ccsa_pkg::ST_DIV_SEC : ccsa_pkg::ST_DONE;
            end
         end
         ccsa_pkg::ST_DIV_SEC: begin
            if (div_done) begin
               state_in = ccsa_pkg::ST_DIV_MIN;
            end
         end
         ccsa_pkg::ST_DIV_MIN: begin
            if (div_done) begin
               state_in = ccsa_pkg::ST_DIV_HOUR;
            end
         end
         ccsa_pkg::ST_DIV_HOUR: begin
            if (div_done) begin
               state_in = ccsa_pkg::ST_WALK;
            end
         end
         ccsa_pkg::ST_WALK: begin
            if (settled) begin
               state_in = ccsa_pkg::ST_DONE;
            end
         end
         ccsa_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = ccsa_pkg::ST_IDLE;
            end
         end
         default: state_in = ccsa_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      div_start    = 1'b0;
      div_dividend = {1'b0, req_data.val_c} + ccsa_pkg::DivW'(second_ff);
      div_divisor  = ccsa_pkg::DvsrSixty;
      date_ctrl    = '0;
      load_rsp     = 1'b0;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      second_in    = second_ff;
      case (state_ff)
         ccsa_pkg::ST_IDLE: begin
            date_ctrl.clr_wrap = accept;
            date_ctrl.set_date = accept && (req_data.op == ccsa_pkg::OP_SET_DATE);
            div_start          = accept && is_add;
            if (accept && (req_data.op == ccsa_pkg::OP_SET_TIME)) begin
               hour_in   = (req_data.val_a > 14'(ccsa_pkg::HourMax)) ? ccsa_pkg::HourMax
                                                                   : req_data.val_a[4:0];
               minute_in = (req_data.val_b > ccsa_pkg::MinuteMax) ? ccsa_pkg::MinuteMax
                                                                 : req_data.val_b;
               second_in = (req_data.val_c > 32'(ccsa_pkg::SecondMax)) ? ccsa_pkg::SecondMax
                                                                      : req_data.val_c[5:0];
            end
         end
         ccsa_pkg::ST_DIV_SEC: begin
            div_dividend = div_quo + ccsa_pkg::DivW'(minute_ff);
            div_start    = div_done;
            if (div_done) begin
               second_in = div_rem;
            end
         end
         ccsa_pkg::ST_DIV_MIN: begin
            div_dividend = div_quo + ccsa_pkg::DivW'(hour_ff);
            div_divisor  = ccsa_pkg::DvsrDay;
            div_start    = div_done;
            if (div_done) begin
               minute_in = div_rem;
            end
         end
         ccsa_pkg::ST_DIV_HOUR: begin
            date_ctrl.walk_load = div_done;
            if (div_done) begin
               hour_in = div_rem[ccsa_pkg::HourW-1:0];
            end
         end
         ccsa_pkg::ST_WALK: begin
            date_ctrl.walk_step = 1'b1;
         end
         ccsa_pkg::ST_DONE: begin
            load_rsp = slot_free;
         end
         default: begin
            load_rsp = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ccsa_pkg::ST_IDLE;
         hour_ff      <= '0;
         minute_ff    <= '0;
         second_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hour_ff      <= hour_in;
         minute_ff    <= minute_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff.out_year     <= cur_year;
         rsp_data_ff.out_month    <= cur_month;
         rsp_data_ff.out_day      <= cur_day;
         rsp_data_ff.out_hour     <= hour_ff;
         rsp_data_ff.out_minute   <= minute_ff;
         rsp_data_ff.out_second   <= second_ff;
         rsp_data_ff.year_wrapped <= wrapped;
      end
   end

   ccsa_div_unit u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   ccsa_date_unit u_date (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (date_ctrl),
      .set_year  (set_year),
      .set_month (set_month),
      .set_day   (set_day),
      .add_days  (div_quo[ccsa_pkg::DayAccW-1:0]),
      .year      (cur_year),
      .month     (cur_month),
      .day       (cur_day),
      .wrapped   (wrapped),
      .settled   (settled)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
